### hw/rtl/knc_pkg.sv
// Shared types and constants for the k-nearest candidate selector.
// No dependencies; used by scoped names in knc_cmp, the top level and the testbench.
package knc_pkg;

	// Operation codes carried on the input tuser.
	localparam logic [1:0] OP_OFFER = 2'd0;
	localparam logic [1:0] OP_CLEAR = 2'd1;
	localparam logic [1:0] OP_DRAIN = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] REG_QUERY_COUNT    = 2'd0;
	localparam logic [1:0] REG_INITIAL_RADIUS = 2'd1;

	// Fixed field widths.
	localparam int OP_W     = 2;
	localparam int DIST_W   = 32;
	localparam int COUNT_W  = 6;
	localparam int CFG_A_W  = 2;
	localparam int CFG_D_W  = 32;

	// Register reset values.
	localparam logic [COUNT_W-1:0] QUERY_COUNT_RST    = 6'd8;
	localparam logic [DIST_W-1:0]  INITIAL_RADIUS_RST = 32'h7F80_0000;

endpackage

### hw/rtl/knc_cmp.sv
// Shared ordering unit: tells whether candidate a orders strictly before b.
// Orders by distance key as unsigned, then by the smaller index. Uses knc_pkg.
module knc_cmp #(
	parameter int INDEX_BITS = 20
) (
	input  logic [knc_pkg::DIST_W-1:0] a_dist,
	input  logic [INDEX_BITS-1:0]      a_idx,
	input  logic [knc_pkg::DIST_W-1:0] b_dist,
	input  logic [INDEX_BITS-1:0]      b_idx,
	output logic                       a_first
);

	// Key compare first, index only breaks ties.
	always_comb begin
		if (a_dist != b_dist) begin
			a_first = a_dist < b_dist;
		end else begin
			a_first = a_idx < b_idx;
		end
	end

endmodule

### hw/rtl/knc_store.sv
// Entry store: one write port and one registered read port.
// Each word holds a distance key above a candidate index.
module knc_store #(
	parameter int DEPTH  = 32,
	parameter int ADDR_W = 5,
	parameter int ENT_W  = 52
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [ENT_W-1:0]  wr_data,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [ENT_W-1:0]  rd_data
);

	logic [ENT_W-1:0] mem [DEPTH];
	logic [ENT_W-1:0] rd_data_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read port, data registered.
	always_ff @(posedge clk) begin
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

### hw/rtl/k_nearest_candidate_selector.sv
// Offer without a walk, clear, unused op and empty drain go from idle through the check
// state to the result state. An insertion walk waits for a read and compares once per entry
// shifted up, then stops on a compare or fills slot 0. A drain reads and emits each held entry.
// One item in work at a time; input is not ready until it ends, and result stalls hold it.
// arst_n clears the sequencer, the held count and the configuration registers.
// The entry store is not cleared; only entries below the held count are read.
module k_nearest_candidate_selector #(
	parameter int MAX_KEPT   = 32,
	parameter int INDEX_BITS = 20,
	localparam int IN_W  = ((INDEX_BITS + knc_pkg::DIST_W + 7) / 8) * 8,
	localparam int OUT_W = ((INDEX_BITS + 2 * knc_pkg::DIST_W + knc_pkg::COUNT_W + 1 + 7) / 8) * 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// Input beat.
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [IN_W-1:0]              s_tdata,  // candidate_index, distance_key
	input  logic [knc_pkg::OP_W-1:0]     s_tuser,  // opcode
	// Result beat.
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [OUT_W-1:0]             m_tdata,  // accepted, held_count, search_radius,
	                                               // out_index, out_distance
	output logic                         m_tlast,
	// Configuration writes.
	input  logic                         cfg_we,
	input  logic [knc_pkg::CFG_A_W-1:0]  cfg_addr,
	input  logic [knc_pkg::CFG_D_W-1:0]  cfg_wdata
);

	localparam int DW     = knc_pkg::DIST_W;
	localparam int CNT_W  = $clog2(MAX_KEPT + 1);
	localparam int ADDR_W = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
	localparam int ENT_W  = DW + INDEX_BITS;
	localparam int LW     = (CNT_W > knc_pkg::COUNT_W) ? CNT_W : knc_pkg::COUNT_W;

	typedef enum logic [7:0] {
		ST_IDLE       = 8'b0000_0001,
		ST_CHECK      = 8'b0000_0010,
		ST_WALK_WAIT  = 8'b0000_0100,
		ST_WALK_CMP   = 8'b0000_1000,
		ST_WALK_PUT   = 8'b0001_0000,
		ST_DRAIN_WAIT = 8'b0010_0000,
		ST_DRAIN_OUT  = 8'b0100_0000,
		ST_EMIT       = 8'b1000_0000
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [knc_pkg::COUNT_W-1:0] qcount_q;
	logic [DW-1:0]               init_radius_q;

	// Current item and walk state.
	logic [knc_pkg::OP_W-1:0] op_q;
	logic [INDEX_BITS-1:0]    offer_idx_q;
	logic [DW-1:0]            offer_dist_q;
	logic [CNT_W-1:0]         held_q;
	logic [ADDR_W-1:0]        pos_q;
	logic                     first_q;
	logic                     emit_acc_q;
	logic [DW-1:0]            tail_dist_q;
	logic [INDEX_BITS-1:0]    tail_idx_q;

	// Result register.
	logic                         m_valid_q;
	logic                         res_acc_q;
	logic [knc_pkg::COUNT_W-1:0]  res_held_q;
	logic [DW-1:0]                res_radius_q;
	logic [INDEX_BITS-1:0]        res_idx_q;
	logic [DW-1:0]                res_dist_q;
	logic                         res_last_q;

	// Store and compare wiring.
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [ENT_W-1:0]  wr_data;
	logic [ADDR_W-1:0] rd_addr;
	logic [ENT_W-1:0]  rd_data;
	logic [DW-1:0]     rd_dist;
	logic [INDEX_BITS-1:0] rd_idx;
	logic [DW-1:0]     cmp_b_dist;
	logic [INDEX_BITS-1:0] cmp_b_idx;
	logic              offer_first;

	// Derived control.
	logic [LW-1:0]     limit;
	logic [LW-1:0]     qcount_ext;
	logic [LW-1:0]     held_ext;
	logic              not_full;
	logic              do_insert;
	logic [CNT_W-1:0]  held_new;
	logic [ADDR_W-1:0] pos_new;
	logic              out_free;
	logic              res_load;
	logic              drain_last;
	logic [DW-1:0]     radius_now;
	logic [ENT_W-1:0]  offer_ent;

	assign rd_dist   = rd_data[ENT_W-1:INDEX_BITS];
	assign rd_idx    = rd_data[INDEX_BITS-1:0];
	assign offer_ent = {offer_dist_q, offer_idx_q};

	// Kept limit: zero acts as one, anything above the store depth as the depth.
	always_comb begin
		qcount_ext = LW'(qcount_q);
		held_ext   = LW'(held_q);
		if (qcount_q == '0) begin
			limit = LW'(1);
		end else if (qcount_ext > LW'(MAX_KEPT)) begin
			limit = LW'(MAX_KEPT);
		end else begin
			limit = qcount_ext;
		end
	end

	// Shared compare: against the farthest entry while checking, else the read word.
	always_comb begin
		if (state_q == ST_CHECK) begin
			cmp_b_dist = tail_dist_q;
			cmp_b_idx  = tail_idx_q;
		end else begin
			cmp_b_dist = rd_dist;
			cmp_b_idx  = rd_idx;
		end
	end

	knc_cmp #(
		.INDEX_BITS(INDEX_BITS)
	) u_cmp (
		.a_dist (offer_dist_q),
		.a_idx  (offer_idx_q),
		.b_dist (cmp_b_dist),
		.b_idx  (cmp_b_idx),
		.a_first(offer_first)
	);

	// Admission decision and the slot where the walk starts.
	always_comb begin
		not_full  = (held_ext < limit) && (held_q < CNT_W'(MAX_KEPT));
		do_insert = (op_q == knc_pkg::OP_OFFER) && (not_full || ((held_q != '0) && offer_first));
		held_new  = not_full ? held_q + CNT_W'(1) : held_q;
		pos_new   = ADDR_W'(held_new - CNT_W'(1));
	end

	// Store write: shifted entry or the offer itself.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = pos_q;
		wr_data = offer_ent;
		case (state_q)
			ST_CHECK: begin
				wr_en   = do_insert && (pos_new == '0);
				wr_addr = '0;
			end
			ST_WALK_CMP: begin
				wr_en   = 1'b1;
				wr_data = offer_first ? rd_data : offer_ent;
			end
			ST_WALK_PUT: begin
				wr_en   = 1'b1;
				wr_addr = '0;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	// Drain reads the pointer slot; the walk reads the slot below it.
	assign rd_addr = ((state_q == ST_DRAIN_WAIT) || (state_q == ST_DRAIN_OUT)) ?
		pos_q : pos_q - ADDR_W'(1);

	knc_store #(
		.DEPTH (MAX_KEPT),
		.ADDR_W(ADDR_W),
		.ENT_W (ENT_W)
	) u_store (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	assign out_free   = !m_valid_q || m_tready;
	assign res_load   = ((state_q == ST_EMIT) || (state_q == ST_DRAIN_OUT)) && out_free;
	assign drain_last = (CNT_W'(pos_q) + CNT_W'(1)) == held_q;
	assign radius_now = ((held_q != '0) && (held_ext >= limit)) ? tail_dist_q : init_radius_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qcount_q      <= knc_pkg::QUERY_COUNT_RST;
			init_radius_q <= knc_pkg::INITIAL_RADIUS_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				knc_pkg::REG_QUERY_COUNT:    qcount_q      <= cfg_wdata[knc_pkg::COUNT_W-1:0];
				knc_pkg::REG_INITIAL_RADIUS: init_radius_q <= cfg_wdata;
				default:                     qcount_q      <= qcount_q;
			endcase
		end
	end

	// Sequencer and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			held_q    <= '0;
			pos_q     <= '0;
			first_q   <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			// A new result beat is loaded only once the previous one has gone.
			if (res_load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						op_q         <= s_tuser;
						offer_idx_q  <= s_tdata[INDEX_BITS-1:0];
						offer_dist_q <= s_tdata[INDEX_BITS+DW-1:INDEX_BITS];
						state_q      <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					case (op_q)
						knc_pkg::OP_OFFER: begin
							emit_acc_q <= do_insert;
							if (do_insert) begin
								held_q  <= held_new;
								pos_q   <= pos_new;
								first_q <= 1'b1;
								if (pos_new == '0) begin
									tail_dist_q <= offer_dist_q;
									tail_idx_q  <= offer_idx_q;
									state_q     <= ST_EMIT;
								end else begin
									state_q <= ST_WALK_WAIT;
								end
							end else begin
								state_q <= ST_EMIT;
							end
						end
						knc_pkg::OP_CLEAR: begin
							emit_acc_q <= 1'b0;
							held_q     <= '0;
							state_q    <= ST_EMIT;
						end
						knc_pkg::OP_DRAIN: begin
							emit_acc_q <= 1'b0;
							if (held_q != '0) begin
								pos_q   <= '0;
								state_q <= ST_DRAIN_WAIT;
							end else begin
								state_q <= ST_EMIT;
							end
						end
						default: begin
							emit_acc_q <= 1'b0;
							state_q    <= ST_EMIT;
						end
					endcase
				end
				ST_WALK_WAIT: begin
					state_q <= ST_WALK_CMP;
				end
				ST_WALK_CMP: begin
					first_q <= 1'b0;
					if (offer_first) begin
						if (first_q) begin
							tail_dist_q <= rd_dist;
							tail_idx_q  <= rd_idx;
						end
						pos_q   <= pos_q - ADDR_W'(1);
						state_q <= (pos_q == ADDR_W'(1)) ? ST_WALK_PUT : ST_WALK_WAIT;
					end else begin
						if (first_q) begin
							tail_dist_q <= offer_dist_q;
							tail_idx_q  <= offer_idx_q;
						end
						state_q <= ST_EMIT;
					end
				end
				ST_WALK_PUT: begin
					state_q <= ST_EMIT;
				end
				ST_DRAIN_WAIT: begin
					state_q <= ST_DRAIN_OUT;
				end
				ST_DRAIN_OUT: begin
					if (out_free) begin
						res_acc_q    <= 1'b0;
						res_held_q   <= knc_pkg::COUNT_W'(held_q);
						res_radius_q <= radius_now;
						res_idx_q    <= rd_idx;
						res_dist_q   <= rd_dist;
						res_last_q   <= drain_last;
						if (drain_last) begin
							state_q <= ST_IDLE;
						end else begin
							pos_q   <= pos_q + ADDR_W'(1);
							state_q <= ST_DRAIN_WAIT;
						end
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						res_acc_q    <= emit_acc_q;
						res_held_q   <= knc_pkg::COUNT_W'(held_q);
						res_radius_q <= radius_now;
						res_idx_q    <= '0;
						res_dist_q   <= '0;
						res_last_q   <= 1'b1;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_valid_q;
	assign m_tlast  = res_last_q;
	assign m_tdata  = OUT_W'({res_dist_q, res_idx_q, res_radius_q, res_held_q, res_acc_q});

endmodule

### hw/rtl/knc_chk.sv
// Port-level checker for the k-nearest candidate selector, bound to the top level.
// Depends on k_nearest_candidate_selector port layout; uses no package items.
module knc_chk #(
	parameter int OUT_W = 96,
	parameter int INDEX_BITS = 20
) (
	input logic             clk,
	input logic             arst_n,
	input logic             s_tvalid,
	input logic             s_tready,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata,
	input logic             m_tlast
);

	localparam int IDX_LO  = 39;
	localparam int DIST_LO = IDX_LO + INDEX_BITS;

	// The block works on one item at a time: no beat right after a taken one.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input taken again in the cycle after an accepted beat");

	// A stalled result beat holds its payload.
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
		else $error("result beat changed while stalled");

	// An accepted offer is a single status beat with no entry payload.
	a_accept_is_status: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[0]) |->
		(m_tlast && (m_tdata[DIST_LO-1:IDX_LO] == '0) && (m_tdata[DIST_LO+31:DIST_LO] == '0)))
		else $error("accepted offer carried entry data or was not last");

	// While a drain still has beats to come, no new input is taken.
	a_drain_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tlast) |-> !s_tready)
		else $error("input ready in the middle of a drain");

endmodule

bind k_nearest_candidate_selector knc_chk #(
	.OUT_W     (OUT_W),
	.INDEX_BITS(INDEX_BITS)
) u_knc_chk (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tlast (m_tlast)
);

### sim/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the k-nearest candidate selector: stream driver, result
// monitor and a behavioral predictor of the sorted candidate store.
// Depends on knc_pkg and k_nearest_candidate_selector from hw/rtl.
module tb_top;

	localparam int IN_W          = 56;
	localparam int OUT_W         = 96;
	localparam int MAX_KEPT      = 32;
	localparam int QUIET_LIMIT   = 2000;
	localparam int SETTLE_CYCLES = 80;
	localparam int PHASES        = 8;
	localparam int PHASE_BEATS   = 22;

	// The package names only the three defined operations.
	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		logic [1:0]  op;
		logic [19:0] idx;
		logic [31:0] key;
	} query_beat_t;

	typedef struct packed {
		logic        acc;
		logic [5:0]  held;
		logic [31:0] radius;
		logic [19:0] idx;
		logic [31:0] key;
		logic        last;
	} nn_result_t;

	logic                          clk       = 1'b0;
	logic                          arst_n    = 1'b0;
	logic                          s_tvalid  = 1'b0;
	logic                          s_tready;
	logic [IN_W-1:0]               s_tdata   = '0;  // candidate_index, distance_key
	logic [knc_pkg::OP_W-1:0]      s_tuser   = '0;  // opcode
	logic                          m_tvalid;
	logic                          m_tready  = 1'b0;
	logic [OUT_W-1:0]              m_tdata;         // accepted, held_count, search_radius,
	                                                // out_index, out_distance
	logic                          m_tlast;
	logic                          cfg_we    = 1'b0;
	logic [knc_pkg::CFG_A_W-1:0]   cfg_addr  = '0;
	logic [knc_pkg::CFG_D_W-1:0]   cfg_wdata = '0;

	k_nearest_candidate_selector i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	query_beat_t pending_beats[$];
	nn_result_t  expected_results[$];
	query_beat_t drive_beat;

	// Predictor copy of the registers and the sorted store.
	logic [5:0]  kept_count_reg = knc_pkg::QUERY_COUNT_RST;
	logic [31:0] radius_reg     = knc_pkg::INITIAL_RADIUS_RST;
	logic [31:0] held_dist[MAX_KEPT];
	logic [19:0] held_idx[MAX_KEPT];
	int          held_n = 0;

	logic no_idle      = 1'b0;
	int   error_count  = 0;
	int   beat_count   = 0;
	int   result_count = 0;
	int   write_count  = 0;
	int   quiet_cycles = 0;

	// Clock.
	initial begin
		forever #6 clk = ~clk;
	end

	function automatic int kept_limit_of(input logic [5:0] qc);
		if (qc == 6'd0) return 1;
		if (qc > MAX_KEPT) return MAX_KEPT;
		return int'(qc);
	endfunction

	// Distance first, then the smaller index.
	function automatic logic orders_first(input logic [31:0] da, input logic [19:0] ia,
	                                      input logic [31:0] db, input logic [19:0] ib);
		if (da != db) return da < db;
		return ia < ib;
	endfunction

	function automatic logic [31:0] radius_now();
		if (held_n > 0 && held_n >= kept_limit_of(kept_count_reg)) return held_dist[held_n-1];
		return radius_reg;
	endfunction

	task automatic push_status(input logic acc, input logic [19:0] oi, input logic [31:0] od,
	                           input logic last);
		nn_result_t r;
		r.acc    = acc;
		r.held   = held_n[5:0];
		r.radius = radius_now();
		r.idx    = oi;
		r.key    = od;
		r.last   = last;
		expected_results.insert(expected_results.size(), r);
	endtask

	// Shift farther entries up one slot and drop the new one into its place.
	task automatic insert_candidate(input logic [31:0] d, input logic [19:0] i);
		int pos;
		pos = held_n;
		while (pos > 0 && orders_first(d, i, held_dist[pos-1], held_idx[pos-1])) begin
			held_dist[pos] = held_dist[pos-1];
			held_idx[pos]  = held_idx[pos-1];
			pos--;
		end
		held_dist[pos] = d;
		held_idx[pos]  = i;
		held_n++;
	endtask

	// Apply one accepted input beat to the predictor and queue the results it causes.
	task automatic select_candidates(input query_beat_t b);
		int   k;
		logic acc;
		case (b.op)
			knc_pkg::OP_OFFER: begin
				acc = 1'b0;
				if (held_n < kept_limit_of(kept_count_reg) && held_n < MAX_KEPT) begin
					insert_candidate(b.key, b.idx);
					acc = 1'b1;
				end else if (held_n > 0 &&
				             orders_first(b.key, b.idx, held_dist[held_n-1], held_idx[held_n-1])) begin
					held_n--;
					insert_candidate(b.key, b.idx);
					acc = 1'b1;
				end
				push_status(acc, '0, '0, 1'b1);
			end
			knc_pkg::OP_CLEAR: begin
				held_n = 0;
				push_status(1'b0, '0, '0, 1'b1);
			end
			knc_pkg::OP_DRAIN: begin
				if (held_n == 0) begin
					push_status(1'b0, '0, '0, 1'b1);
				end else begin
					for (k = 0; k < held_n; k++)
						push_status(1'b0, held_idx[k], held_dist[k], k == held_n - 1);
				end
			end
			default: begin
				push_status(1'b0, '0, '0, 1'b1);
			end
		endcase
	endtask

	task automatic report_mismatch(input string what);
		error_count++;
		$display("tb_top: mismatch on result %0d: %s", result_count, what);
	endtask

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got)
			report_mismatch($sformatf("%s expected 0x%08h, got 0x%08h", name, want, got));
	endtask

	// Input driver: present the next pending beat once the current one is taken.
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				select_candidates(drive_beat);
				beat_count++;
			end
			if (!s_tvalid || s_tready) begin
				if (pending_beats.size() != 0 && (no_idle || $urandom_range(0, 99) >= 9)) begin
					drive_beat = pending_beats.pop_front();
					s_tvalid  <= 1'b1;
					s_tdata   <= {4'b0, drive_beat.key, drive_beat.idx};
					s_tuser   <= drive_beat.op;
				end else begin
					s_tvalid  <= 1'b0;
				end
			end
		end
	end

	// Result monitor: random back-pressure and field-by-field comparison.
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_results.size() == 0) begin
					report_mismatch("result beat with nothing outstanding");
				end else begin
					nn_result_t want;
					want = expected_results.pop_front();
					check_field("accepted", want.acc, m_tdata[0]);
					check_field("held_count", want.held, m_tdata[6:1]);
					check_field("search_radius", want.radius, m_tdata[38:7]);
					check_field("out_index", want.idx, m_tdata[58:39]);
					check_field("out_distance", want.key, m_tdata[90:59]);
					check_field("last", want.last, m_tlast);
				end
				result_count++;
			end
			m_tready <= no_idle || ($urandom_range(0, 99) >= 9);
		end
	end

	// Watchdog on cycles with no traffic at all.
	always @(posedge clk) begin
		if (arst_n && !((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we))
			quiet_cycles <= quiet_cycles + 1;
		else
			quiet_cycles <= 0;
	end

	initial begin
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("tb_top: no beat moved for %0d cycles", QUIET_LIMIT);
		$display("tb_top: errors");
		$finish;
	end

	task automatic push_beat(input logic [1:0] op, input logic [19:0] idx, input logic [31:0] key);
		query_beat_t b;
		b.op  = op;
		b.idx = idx;
		b.key = key;
		pending_beats.insert(pending_beats.size(), b);
	endtask

	// Hold the sender until every queued beat is taken and every result has come back.
	task automatic wait_drained();
		do @(negedge clk);
		while (pending_beats.size() != 0 || s_tvalid || expected_results.size() != 0);
	endtask

	task automatic write_register(input logic [1:0] addr, input logic [31:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_addr  <= addr;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		if (addr == knc_pkg::REG_QUERY_COUNT)
			kept_count_reg = value[5:0];
		else
			radius_reg = value;
		write_count++;
	endtask

	// Keys cluster in a small range often, so ties and duplicates are common.
	function automatic logic [31:0] random_key();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40) return $urandom_range(0, 15);
		if (r < 50) return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
		return $urandom();
	endfunction

	function automatic logic [19:0] random_index();
		if ($urandom_range(0, 1)) return $urandom_range(0, 7);
		return $urandom_range(0, 20'hF_FFFF);
	endfunction

	// Mostly whole queries (clear, offers, drain), with a little noise mixed in.
	task automatic fill_phase(input int n_beats);
		int used;
		int offers;
		int r;
		used = 0;
		while (used < n_beats) begin
			if ($urandom_range(0, 99) < 85) begin
				push_beat(knc_pkg::OP_CLEAR, random_index(), random_key());
				used++;
			end
			offers = $urandom_range(1, kept_limit_of(kept_count_reg) + 6);
			repeat (offers) begin
				r = $urandom_range(0, 99);
				if (r < 3)
					push_beat(OP_UNUSED, $urandom_range(0, 20'hF_FFFF), $urandom());
				else if (r < 5)
					push_beat(knc_pkg::OP_DRAIN, random_index(), random_key());
				else if (r < 6)
					push_beat(knc_pkg::OP_CLEAR, random_index(), random_key());
				else
					push_beat(knc_pkg::OP_OFFER, random_index(), random_key());
			end
			used += offers;
			push_beat(knc_pkg::OP_DRAIN, random_index(), random_key());
			used++;
		end
	endtask

	initial begin
		logic [5:0]  phase_count[PHASES];
		logic [31:0] phase_radius[PHASES];
		int p;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part at reset settings: empty drain, unused code, extremes, ties,
		// duplicates, filling up, rejection of an exact match of the farthest entry.
		push_beat(knc_pkg::OP_DRAIN, 20'h0, 32'h0);
		push_beat(OP_UNUSED,         20'hF_FFFF, 32'hFFFF_FFFF);
		push_beat(knc_pkg::OP_OFFER, 20'h0, 32'h0);
		push_beat(knc_pkg::OP_OFFER, 20'hF_FFFF, 32'hFFFF_FFFF);
		push_beat(knc_pkg::OP_OFFER, 20'd7, 32'd5);
		push_beat(knc_pkg::OP_OFFER, 20'd3, 32'd5);
		push_beat(knc_pkg::OP_OFFER, 20'd7, 32'd5);
		push_beat(knc_pkg::OP_OFFER, 20'd1, 32'h3F80_0000);
		push_beat(knc_pkg::OP_OFFER, 20'd2, 32'h7F80_0000);
		push_beat(knc_pkg::OP_OFFER, 20'd9, 32'd1);
		push_beat(knc_pkg::OP_OFFER, 20'hF_FFFF, 32'hFFFF_FFFF);
		push_beat(knc_pkg::OP_OFFER, 20'hF_FFFE, 32'hFFFF_FFFF);
		push_beat(knc_pkg::OP_OFFER, 20'h0, 32'h0);
		push_beat(knc_pkg::OP_DRAIN, 20'h0, 32'h0);
		push_beat(OP_UNUSED,         20'h0, 32'h0);
		wait_drained();

		// Lower the count while eight entries are held; the store stays over-full.
		write_register(knc_pkg::REG_QUERY_COUNT, 32'd2);
		write_register(knc_pkg::REG_INITIAL_RADIUS, 32'h0);
		push_beat(knc_pkg::OP_OFFER, 20'd4, 32'd2);
		push_beat(knc_pkg::OP_OFFER, 20'h1_2345, 32'h8000_0000);
		push_beat(knc_pkg::OP_DRAIN, 20'h0, 32'h0);
		push_beat(knc_pkg::OP_CLEAR, 20'h0, 32'h0);
		push_beat(knc_pkg::OP_DRAIN, 20'h0, 32'h0);
		push_beat(knc_pkg::OP_OFFER, 20'hA_5A5A, 32'h5A5A_5A5A);
		push_beat(knc_pkg::OP_OFFER, 20'h5_A5A5, 32'hA5A5_A5A5);
		push_beat(knc_pkg::OP_DRAIN, 20'h0, 32'h0);
		wait_drained();

		// Random queries under a series of register settings, extremes included.
		phase_count[0] = 6'd0;
		phase_count[1] = 6'd1;
		phase_count[2] = 6'd32;
		phase_count[3] = 6'd63;
		phase_count[4] = 6'd5;
		phase_count[5] = 6'd40;
		phase_count[6] = 6'd16;
		phase_count[7] = 6'd3;
		phase_radius[0] = 32'h0;
		phase_radius[1] = 32'hFFFF_FFFF;
		phase_radius[2] = $urandom();
		phase_radius[3] = knc_pkg::INITIAL_RADIUS_RST;
		phase_radius[4] = $urandom();
		phase_radius[5] = 32'h3F80_0000;
		phase_radius[6] = $urandom();
		phase_radius[7] = $urandom();
		for (p = 0; p < PHASES; p++) begin
			write_register(knc_pkg::REG_QUERY_COUNT, {26'b0, phase_count[p]});
			write_register(knc_pkg::REG_INITIAL_RADIUS, phase_radius[p]);
			no_idle = (p == 4);
			fill_phase(PHASE_BEATS);
			wait_drained();
		end
		no_idle = 1'b0;

		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("tb_top: %0d input beats, %0d result beats, %0d register writes",
		         beat_count, result_count, write_count);
		$display("tb_top: query counts 0 to 63 with edge radii, ties, over-full store");
		if (error_count == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule

### sim.f
hw/rtl/knc_pkg.sv
hw/rtl/knc_cmp.sv
hw/rtl/knc_store.sv
hw/rtl/k_nearest_candidate_selector.sv
hw/rtl/knc_chk.sv
sim/tb_top.sv
